>>> rtl/core/trs_pkg.sv
// Shared types, constants and helpers of the reverse-sequence tensor core.
// Used by the front end, the command queue, the execution engine and the top level.
// No dependencies.
package trs_pkg;

  localparam int unsigned IDX_W       = 12;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned EXT_W       = 13;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned NUM_DIMS    = 4;
  localparam int unsigned DIM_W       = 2;
  localparam int unsigned S_TDATA_W   = 64;
  localparam int unsigned APB_AW      = 5;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIV_STEP    = 4;
  localparam int unsigned DIV_CYCLES  = IDX_W / DIV_STEP;
  localparam int unsigned DIV_CNT_W   = 2;

  localparam int unsigned DEF_MAX_ELEMENTS = 4096;
  localparam int unsigned DEF_MAX_BATCHES  = 256;

  // Command codes on the input stream.
  localparam logic [CMD_W-1:0] CMD_WR_ELEM = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_LEN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // Register indexes on the configuration port (byte address / 4).
  localparam logic [2:0] REG_SIZE_DIM0  = 3'd0;
  localparam logic [2:0] REG_SIZE_DIM1  = 3'd1;
  localparam logic [2:0] REG_SIZE_DIM2  = 3'd2;
  localparam logic [2:0] REG_SIZE_DIM3  = 3'd3;
  localparam logic [2:0] REG_SEQ_AXIS   = 3'd4;
  localparam logic [2:0] REG_BATCH_AXIS = 3'd5;

  typedef enum logic [1:0] {
    OP_WR_ELEM,
    OP_WR_LEN,
    OP_READ
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOTAL,
    ST_CHECK,
    ST_DIV,
    ST_LEN,
    ST_REV,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [EXT_W-1:0] size_dim0;
    logic [EXT_W-1:0] size_dim1;
    logic [EXT_W-1:0] size_dim2;
    logic [EXT_W-1:0] size_dim3;
    logic [DIM_W-1:0] seq_axis;
    logic [DIM_W-1:0] batch_axis;
  } trs_cfg_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] seq_len;
  } trs_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } trs_qstat_t;

  // Extent of one dimension; a zero extent counts as one.
  function automatic logic [EXT_W-1:0] ext_of(trs_cfg_t cfg, logic [DIM_W-1:0] dim);
    logic [EXT_W-1:0] e;
    case (dim)
      2'd0:    e = cfg.size_dim0;
      2'd1:    e = cfg.size_dim1;
      2'd2:    e = cfg.size_dim2;
      default: e = cfg.size_dim3;
    endcase
    if (e == '0) begin
      e = EXT_W'(1);
    end
    return e;
  endfunction

endpackage

>>> rtl/core/trs_front.sv
// Front end of the reverse-sequence core: accepts stream words and classifies them.
// Unused commands and out-of-range writes are dropped here. Depends on trs_pkg.
module trs_front #(
  parameter int unsigned MAX_ELEMENTS = trs_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned MAX_BATCHES  = trs_pkg::DEF_MAX_BATCHES
) (
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [trs_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  logic [trs_pkg::CMD_W-1:0]      s_tuser_i,
  input  trs_pkg::trs_qstat_t            qstat_i,
  input  logic                           clearing_i,
  output logic                           push_o,
  output trs_pkg::trs_item_t             item_o
);
  import trs_pkg::*;

  logic [IDX_W-1:0] index;
  logic             keep;
  op_e              op;

  assign index = s_tdata_i[IDX_W-1:0];

  always_comb begin
    op   = OP_READ;
    keep = 1'b0;
    case (s_tuser_i)
      CMD_WR_ELEM: begin
        op   = OP_WR_ELEM;
        keep = 32'(index) < 32'(MAX_ELEMENTS);
      end
      CMD_WR_LEN: begin
        op   = OP_WR_LEN;
        keep = 32'(index) < 32'(MAX_BATCHES);
      end
      CMD_READ: begin
        op   = OP_READ;
        keep = 1'b1;
      end
      default: begin
        op   = OP_READ;
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready_o     = !qstat_i.full && !clearing_i;
  assign push_o         = s_tvalid_i && s_tready_o && keep;
  assign item_o.op      = op;
  assign item_o.index   = index;
  assign item_o.value   = s_tdata_i[IDX_W +: VAL_W];
  assign item_o.seq_len = s_tdata_i[IDX_W+VAL_W +: LEN_W];

endmodule

>>> rtl/core/trs_fifo.sv
// Short command queue between the front end and the execution engine.
// Holds classified items so both sides stall independently. Depends on trs_pkg.
module trs_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  trs_pkg::trs_item_t   item_i,
  input  logic                 pop_i,
  output trs_pkg::trs_item_t   item_o,
  output trs_pkg::trs_qstat_t  stat_o
);
  import trs_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  trs_item_t     slots_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PW:0]   count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (PW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = slots_q[rd_ptr_q];
  assign stat_o.full  = (32'(count_q) == QUEUE_DEPTH);
  assign stat_o.empty = (count_q == '0);

endmodule

>>> rtl/core/trs_back.sv
// Execution engine of the reverse-sequence core: element store, length table,
// shared radix-16 index divider, address rebuild and the result register. Depends on trs_pkg.
module trs_back #(
  parameter int unsigned MAX_ELEMENTS = trs_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned MAX_BATCHES  = trs_pkg::DEF_MAX_BATCHES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  trs_pkg::trs_cfg_t           cfg_i,
  input  trs_pkg::trs_item_t          q_item_i,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  output logic                        clearing_o,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [trs_pkg::ELEM_W-1:0]  m_data_o,
  output logic                        m_oor_o
);
  import trs_pkg::*;

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned LW = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
  // Index arithmetic saturates at all ones of FW bits, which is above both
  // any read index and the store depth, so every compare stays exact.
  localparam int unsigned FW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [FW-1:0] MAX_EL_F = FW'(MAX_ELEMENTS);

  state_e st_q, st_d;

  logic [DIM_W-1:0]     dim_q, dim_d;
  logic [FW-1:0]        acc_q, acc_d;
  logic [FW-1:0]        stride_q, stride_d;
  logic [EXT_W-1:0]     seq_ext_q, seq_ext_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [EXT_W-1:0]     rem_q, rem_d;
  logic [IDX_W-1:0]     dvd_q, dvd_d;
  logic [DIV_CNT_W-1:0] grp_q, grp_d;
  logic [IDX_W-1:0]     s_q, s_d;
  logic [IDX_W-1:0]     b_q, b_d;
  logic                 b_ok_q, b_ok_d;
  logic                 neg_q, neg_d;
  logic [IDX_W-1:0]     mag_q, mag_d;
  logic [FW-1:0]        prod_q, prod_d;
  logic                 rd_ok_q, rd_ok_d;
  logic                 oor_q, oor_d;
  logic                 out_valid_q, out_valid_d;
  logic [ELEM_W-1:0]    out_data_q, out_data_d;
  logic                 out_oor_q, out_oor_d;
  logic                 clr_q, clr_d;
  logic [LW-1:0]        clr_cnt_q, clr_cnt_d;

  logic [ELEM_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [ELEM_W-1:0] elem_rd_q;
  logic              elem_we, elem_re;
  logic [AW-1:0]     elem_waddr, elem_raddr;
  logic [LEN_W-1:0]  len_mem [MAX_BATCHES];
  logic [LEN_W-1:0]  len_rd_q;
  logic              len_we, len_re;
  logic [LW-1:0]     len_waddr, len_raddr;
  logic [LEN_W-1:0]  len_wdata;

  logic [EXT_W-1:0]       e_cur;
  logic [EXT_W-1:0]       div_rem;
  logic [IDX_W-1:0]       div_dvd;
  logic [FW+EXT_W-1:0]    tot_full;
  logic [FW+IDX_W-1:0]    prod_full;
  logic [FW:0]            flat_full;
  logic [FW-1:0]          flat;
  logic [LEN_W-1:0]       len_raw, len_c;
  logic [EXT_W-1:0]       s_ext, s_new;

  assign e_cur = ext_of(cfg_i, dim_q);

  // Four quotient bits of the restoring division per cycle.
  always_comb begin
    logic [EXT_W:0]   sh;
    logic [EXT_W-1:0] rem_t;
    logic [IDX_W-1:0] dvd_t;
    rem_t = rem_q;
    dvd_t = dvd_q;
    sh    = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      sh    = {rem_t, dvd_t[IDX_W-1]};
      dvd_t = {dvd_t[IDX_W-2:0], 1'b0};
      if (sh >= {1'b0, e_cur}) begin
        rem_t    = EXT_W'(sh - {1'b0, e_cur});
        dvd_t[0] = 1'b1;
      end else begin
        rem_t = sh[EXT_W-1:0];
      end
    end
    div_rem = rem_t;
    div_dvd = dvd_t;
  end

  always_comb begin
    tot_full  = acc_q * e_cur;
    prod_full = mag_q * stride_q;
    if (neg_q) begin
      flat_full = (FW+1)'(idx_q) - (FW+1)'(prod_q);
    end else begin
      flat_full = (FW+1)'(idx_q) + (FW+1)'(prod_q);
    end
    flat    = flat_full[FW] ? '1 : flat_full[FW-1:0];
    len_raw = b_ok_q ? len_rd_q : '0;
    len_c   = (len_raw > seq_ext_q) ? seq_ext_q : len_raw;
    s_ext   = EXT_W'(s_q);
    if (cfg_i.seq_axis != cfg_i.batch_axis && len_c > LEN_W'(1) && s_ext < len_c) begin
      s_new = len_c - EXT_W'(1) - s_ext;
    end else begin
      s_new = s_ext;
    end
  end

  always_comb begin
    st_d        = st_q;
    dim_d       = dim_q;
    acc_d       = acc_q;
    stride_d    = stride_q;
    seq_ext_d   = seq_ext_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    grp_d       = grp_q;
    s_d         = s_q;
    b_d         = b_q;
    b_ok_d      = b_ok_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    rd_ok_d     = rd_ok_q;
    oor_d       = oor_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_data_d  = out_data_q;
    out_oor_d   = out_oor_q;
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    q_pop_o     = 1'b0;
    elem_we     = 1'b0;
    elem_waddr  = AW'(q_item_i.index);
    elem_re     = 1'b0;
    elem_raddr  = flat[AW-1:0];
    len_we      = 1'b0;
    len_waddr   = LW'(q_item_i.index);
    len_wdata   = q_item_i.seq_len;
    len_re      = 1'b0;
    len_raddr   = LW'(b_q);

    // After reset the length table is swept to zero before any item runs.
    if (clr_q) begin
      len_we    = 1'b1;
      len_waddr = clr_cnt_q;
      len_wdata = '0;
      if (32'(clr_cnt_q) == MAX_BATCHES - 1) begin
        clr_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + LW'(1);
      end
    end

    case (st_q)
      ST_IDLE: begin
        if (!clr_q && q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.op)
            OP_WR_ELEM: elem_we = 1'b1;
            OP_WR_LEN:  len_we  = 1'b1;
            OP_READ: begin
              idx_d    = q_item_i.index;
              acc_d    = FW'(1);
              stride_d = FW'(1);
              dim_d    = DIM_W'(NUM_DIMS - 1);
              st_d     = ST_TOTAL;
            end
            default: ;
          endcase
        end
      end
      // Product of extents, innermost first; the running product at the
      // sequence axis is that axis' stride.
      ST_TOTAL: begin
        if (dim_q == cfg_i.seq_axis) begin
          stride_d  = acc_q;
          seq_ext_d = e_cur;
        end
        acc_d = (|tot_full[FW+EXT_W-1:FW]) ? '1 : tot_full[FW-1:0];
        if (dim_q == '0) begin
          st_d = ST_CHECK;
        end else begin
          dim_d = dim_q - DIM_W'(1);
        end
      end
      ST_CHECK: begin
        if (FW'(idx_q) >= acc_q || FW'(idx_q) >= MAX_EL_F) begin
          oor_d   = 1'b1;
          rd_ok_d = 1'b0;
          st_d    = ST_EMIT;
        end else begin
          oor_d = 1'b0;
          dvd_d = idx_q;
          rem_d = '0;
          grp_d = '0;
          dim_d = DIM_W'(NUM_DIMS - 1);
          st_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = div_rem;
        dvd_d = div_dvd;
        grp_d = grp_q + DIV_CNT_W'(1);
        if (32'(grp_q) == DIV_CYCLES - 1) begin
          grp_d = '0;
          rem_d = '0;
          if (dim_q == cfg_i.seq_axis) begin
            s_d = div_rem[IDX_W-1:0];
          end
          if (dim_q == cfg_i.batch_axis) begin
            b_d = div_rem[IDX_W-1:0];
          end
          if (dim_q == '0) begin
            st_d = ST_LEN;
          end else begin
            dim_d = dim_q - DIM_W'(1);
          end
        end
      end
      ST_LEN: begin
        b_ok_d = 32'(b_q) < 32'(MAX_BATCHES);
        len_re = b_ok_d;
        st_d   = ST_REV;
      end
      ST_REV: begin
        if (s_new >= s_ext) begin
          neg_d = 1'b0;
          mag_d = IDX_W'(s_new - s_ext);
        end else begin
          neg_d = 1'b1;
          mag_d = IDX_W'(s_ext - s_new);
        end
        st_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d = (|prod_full[FW+IDX_W-1:FW]) ? '1 : prod_full[FW-1:0];
        st_d   = ST_ADD;
      end
      ST_ADD: begin
        rd_ok_d = flat < MAX_EL_F;
        elem_re = rd_ok_d;
        st_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_ok_q ? elem_rd_q : '0;
          out_oor_d   = oor_q;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dim_q      <= dim_d;
    acc_q      <= acc_d;
    stride_q   <= stride_d;
    seq_ext_q  <= seq_ext_d;
    idx_q      <= idx_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    grp_q      <= grp_d;
    s_q        <= s_d;
    b_q        <= b_d;
    b_ok_q     <= b_ok_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    prod_q     <= prod_d;
    rd_ok_q    <= rd_ok_d;
    oor_q      <= oor_d;
    out_data_q <= out_data_d;
    out_oor_q  <= out_oor_d;
  end

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= q_item_i.value;
    end
    if (elem_re) begin
      elem_rd_q <= elem_mem[elem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (len_re) begin
      len_rd_q <= len_mem[len_raddr];
    end
  end

  assign clearing_o = clr_q;
  assign m_tvalid_o = out_valid_q;
  assign m_data_o   = out_data_q;
  assign m_oor_o    = out_oor_q;

endmodule

>>> rtl/core/tensor_reverse_sequence_core.sv
// Reverse-sequence tensor core, top level: configuration registers and stream ports.
// Instantiates trs_front, trs_fifo and trs_back; depends on trs_pkg.
//
// The core stores a row-major tensor of up to four dimensions and a table of
// per-batch sequence lengths, and answers read commands with the element of the
// tensor reversed along the sequence axis. Element and length writes are done as
// they leave the queue. A read, once taken from the queue, forms the extent
// product one dimension a cycle, checks the range, splits the flat index on the
// shared divider (four quotient bits a cycle, one dimension after another), then
// looks up the length, rebuilds the address, reads the element store and loads
// the result register. An out-of-range read skips the divider and the later steps
// and goes straight to loading the result register. The last step waits while an
// earlier result is still held on the output. A two-entry queue lets new commands
// enter while the engine works and while a result waits on the output. After
// reset the length table is cleared entry by entry, during which no command is
// taken; configuration writes are taken at all times. An out-of-range read
// returns zero data with tuser set.
module tensor_reverse_sequence_core #(
  parameter int unsigned MAX_ELEMENTS = trs_pkg::DEF_MAX_ELEMENTS,
  parameter int unsigned MAX_BATCHES  = trs_pkg::DEF_MAX_BATCHES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trs_pkg::APB_AW-1:0]    paddr,
  input  logic [trs_pkg::APB_DW-1:0]    pwdata,
  output logic [trs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // Command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // index [11:0], value [43:12], seq_len [56:44], zero [63:57]
  input  logic [trs_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd [1:0]
  input  logic [trs_pkg::CMD_W-1:0]     s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // read_data [31:0]
  output logic [trs_pkg::ELEM_W-1:0]    m_axis_tdata,
  // out_of_range [0]
  output logic                          m_axis_tuser
);
  import trs_pkg::*;

  trs_cfg_t   cfg_q, cfg_d;
  logic       cfg_we;
  trs_item_t  push_item, head_item;
  logic       push, pop, clearing;
  trs_qstat_t qstat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (paddr[4:2])
        REG_SIZE_DIM0:  cfg_d.size_dim0  = pwdata[EXT_W-1:0];
        REG_SIZE_DIM1:  cfg_d.size_dim1  = pwdata[EXT_W-1:0];
        REG_SIZE_DIM2:  cfg_d.size_dim2  = pwdata[EXT_W-1:0];
        REG_SIZE_DIM3:  cfg_d.size_dim3  = pwdata[EXT_W-1:0];
        REG_SEQ_AXIS:   cfg_d.seq_axis   = pwdata[DIM_W-1:0];
        REG_BATCH_AXIS: cfg_d.batch_axis = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SIZE_DIM0:  prdata = APB_DW'(cfg_q.size_dim0);
      REG_SIZE_DIM1:  prdata = APB_DW'(cfg_q.size_dim1);
      REG_SIZE_DIM2:  prdata = APB_DW'(cfg_q.size_dim2);
      REG_SIZE_DIM3:  prdata = APB_DW'(cfg_q.size_dim3);
      REG_SEQ_AXIS:   prdata = APB_DW'(cfg_q.seq_axis);
      REG_BATCH_AXIS: prdata = APB_DW'(cfg_q.batch_axis);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_dim0  <= EXT_W'(1);
      cfg_q.size_dim1  <= EXT_W'(1);
      cfg_q.size_dim2  <= EXT_W'(1);
      cfg_q.size_dim3  <= EXT_W'(1);
      cfg_q.seq_axis   <= DIM_W'(1);
      cfg_q.batch_axis <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  trs_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_BATCHES  (MAX_BATCHES)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .qstat_i    (qstat),
    .clearing_i (clearing),
    .push_o     (push),
    .item_o     (push_item)
  );

  trs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (qstat)
  );

  trs_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_BATCHES  (MAX_BATCHES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_item_i   (head_item),
    .q_valid_i  (!qstat.empty),
    .q_pop_o    (pop),
    .clearing_o (clearing),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_oor_o    (m_axis_tuser)
  );

`ifndef SYNTHESIS
  a_oor_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("out-of-range result carries nonzero data");

  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("command accepted during length table clear");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("queue pushed while full");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!qstat.empty && !clearing))
    else $error("queue popped while empty or clearing");
`endif

endmodule

>>> dv/tensor_reverse_sequence_core_tb.sv
// Self-checking testbench for tensor_reverse_sequence_core: element, length and read
// commands on the input stream, reversed-tensor reads checked on the result stream.
// Depends on trs_pkg and the core RTL only.
module tensor_reverse_sequence_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trs_pkg::*;

  localparam int unsigned ELEM_DEPTH  = DEF_MAX_ELEMENTS;
  localparam int unsigned LEN_DEPTH   = DEF_MAX_BATCHES;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic [LEN_W-1:0] seq_len;
  } command_t;

  typedef struct packed {
    logic [ELEM_W-1:0] data;
    logic              oor;
  } read_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [APB_AW-1:0]   paddr   = '0;
  logic [APB_DW-1:0]   pwdata  = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  logic                s_valid = 1'b0;
  logic                s_axis_tready;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic [CMD_W-1:0]    s_user  = '0;
  logic                m_axis_tvalid;
  logic                m_ready = 1'b0;
  logic [ELEM_W-1:0]   m_axis_tdata;
  logic                m_axis_tuser;

  // Configuration as last written; changed only while the core is idle.
  logic [EXT_W-1:0] extent_cfg [NUM_DIMS] = '{default: EXT_W'(1)};
  logic [DIM_W-1:0] seq_axis_cfg   = 2'd1;
  logic [DIM_W-1:0] batch_axis_cfg = 2'd0;

  // Predicted contents of the core, updated as words are accepted.
  logic [ELEM_W-1:0] elem_store [ELEM_DEPTH];
  logic [LEN_W-1:0]  len_table  [LEN_DEPTH] = '{default: '0};

  // Generation-side view, used to avoid reading elements never written.
  bit                gen_written [ELEM_DEPTH];
  logic [LEN_W-1:0]  gen_len     [LEN_DEPTH] = '{default: '0};

  command_t     pending_cmds [$];
  read_result_t expected_reads [$];
  command_t     driven_cmd;
  read_result_t seen_read;
  int unsigned  cmds_issued   = 0;
  int unsigned  cmds_accepted = 0;
  int unsigned  failures      = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;

  tensor_reverse_sequence_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [EXT_W-1:0] ext_of_dim(int d);
    return (extent_cfg[d] == '0) ? EXT_W'(1) : extent_cfg[d];
  endfunction

  function automatic logic [63:0] tensor_total();
    logic [63:0] prod;
    prod = 64'd1;
    for (int d = 0; d < NUM_DIMS; d++) begin
      prod = prod * ext_of_dim(d);
    end
    return prod;
  endfunction

  function automatic logic [NUM_DIMS-1:0][EXT_W-1:0] split_index(logic [IDX_W-1:0] idx);
    logic [NUM_DIMS-1:0][EXT_W-1:0] c;
    logic [63:0] rest;
    rest = idx;
    for (int d = NUM_DIMS - 1; d >= 0; d--) begin
      c[d] = EXT_W'(rest % ext_of_dim(d));
      rest = rest / ext_of_dim(d);
    end
    return c;
  endfunction

  function automatic logic [EXT_W-1:0] batch_of(logic [IDX_W-1:0] idx);
    logic [NUM_DIMS-1:0][EXT_W-1:0] c;
    c = split_index(idx);
    return c[batch_axis_cfg];
  endfunction

  // Flat index of the element that output index idx shows, given its batch's length.
  function automatic logic [63:0] source_index(logic [IDX_W-1:0] idx,
                                               logic [LEN_W-1:0] len_entry);
    logic [NUM_DIMS-1:0][EXT_W-1:0] c;
    logic [LEN_W-1:0] len;
    logic [63:0] flat;
    c = split_index(idx);
    if (seq_axis_cfg != batch_axis_cfg) begin
      len = (len_entry > ext_of_dim(seq_axis_cfg)) ? ext_of_dim(seq_axis_cfg) : len_entry;
      if (len > 1 && c[seq_axis_cfg] < len) begin
        c[seq_axis_cfg] = len - 13'd1 - c[seq_axis_cfg];
      end
    end
    flat = 64'd0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      flat = flat * ext_of_dim(d) + c[d];
    end
    return flat;
  endfunction

  task automatic apply_command(input command_t c);
    logic [EXT_W-1:0] b;
    logic [63:0]      src;
    read_result_t     r;
    case (c.cmd)
      CMD_WR_ELEM: elem_store[c.index] = c.value;
      CMD_WR_LEN: begin
        if (c.index < LEN_DEPTH) begin
          len_table[c.index[7:0]] = c.seq_len;
        end
      end
      CMD_READ: begin
        if (c.index >= tensor_total()) begin
          r.data = '0;
          r.oor  = 1'b1;
        end else begin
          b = batch_of(c.index);
          src = source_index(c.index, (b < LEN_DEPTH) ? len_table[b[7:0]] : '0);
          r.data = (src < ELEM_DEPTH) ? elem_store[src[IDX_W-1:0]] : '0;
          r.oor  = 1'b0;
        end
        expected_reads.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (s_valid && s_axis_tready) begin
        apply_command(driven_cmd);
        cmds_accepted++;
      end
      if (!s_valid || s_axis_tready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          driven_cmd = pending_cmds.pop_front();
          s_valid <= 1'b1;
          s_data  <= {7'd0, driven_cmd.seq_len, driven_cmd.value, driven_cmd.index};
          s_user  <= driven_cmd.cmd;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        if (expected_reads.size() == 0) begin
          $error("unexpected result word: read_data %h out_of_range %b",
                 m_axis_tdata, m_axis_tuser);
          failures++;
        end else begin
          seen_read = expected_reads.pop_front();
          if (m_axis_tdata !== seen_read.data) begin
            $error("read_data mismatch: expected %h, got %h", seen_read.data, m_axis_tdata);
            failures++;
          end
          if (m_axis_tuser !== seen_read.oor) begin
            $error("out_of_range mismatch: expected %b, got %b", seen_read.oor, m_axis_tuser);
            failures++;
          end
        end
      end
      m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                          input logic [VAL_W-1:0] val, input logic [LEN_W-1:0] len);
    command_t c;
    c = '{cmd: cmd, index: idx, value: val, seq_len: len};
    if (cmd == CMD_WR_ELEM) begin
      gen_written[idx] = 1'b1;
    end else if (cmd == CMD_WR_LEN && idx < LEN_DEPTH) begin
      gen_len[idx[7:0]] = len;
    end
    pending_cmds.push_back(c);
    cmds_issued++;
  endtask

  // A read whose source element was never written first gets that element written.
  task automatic push_read(input logic [IDX_W-1:0] idx);
    logic [EXT_W-1:0] b;
    logic [63:0]      src;
    if (idx < tensor_total()) begin
      b = batch_of(idx);
      src = source_index(idx, (b < LEN_DEPTH) ? gen_len[b[7:0]] : '0);
      if (src < ELEM_DEPTH && !gen_written[src[IDX_W-1:0]]) begin
        push_cmd(CMD_WR_ELEM, src[IDX_W-1:0], $urandom, LEN_W'($urandom));
      end
    end
    push_cmd(CMD_READ, idx, $urandom, LEN_W'($urandom));
  endtask

  task automatic random_items(input int n);
    int unsigned      pick, span, nbatch, seq_ext;
    logic [63:0]      tot;
    logic [VAL_W-1:0] val;
    logic [LEN_W-1:0] len;
    tot = tensor_total();
    span = (tot > ELEM_DEPTH) ? ELEM_DEPTH : int'(tot);
    nbatch = (ext_of_dim(batch_axis_cfg) > LEN_DEPTH) ? LEN_DEPTH : ext_of_dim(batch_axis_cfg);
    seq_ext = ext_of_dim(seq_axis_cfg);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        if ($urandom_range(99) < 80) begin
          push_read(IDX_W'($urandom_range(span - 1)));
        end else begin
          push_read(IDX_W'($urandom));
        end
      end else if (pick < 70) begin
        case ($urandom_range(19))
          0:       val = '0;
          1:       val = '1;
          default: val = $urandom;
        endcase
        push_cmd(CMD_WR_ELEM,
                 ($urandom_range(9) < 8) ? IDX_W'($urandom_range(span - 1)) : IDX_W'($urandom),
                 val, LEN_W'($urandom));
      end else if (pick < 95) begin
        case ($urandom_range(9))
          0, 1, 2: len = LEN_W'($urandom_range(3));
          3, 4:    len = LEN_W'($urandom);
          default: len = LEN_W'($urandom_range(seq_ext + 1));
        endcase
        push_cmd(CMD_WR_LEN,
                 ($urandom_range(99) < 85) ? IDX_W'($urandom_range(nbatch - 1))
                                           : IDX_W'($urandom),
                 $urandom, len);
      end else begin
        push_cmd(CMD_UNUSED, IDX_W'($urandom), $urandom, LEN_W'($urandom));
      end
    end
  endtask

  task automatic apb_write(input logic [2:0] reg_idx, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input int unsigned d0, input int unsigned d1, input int unsigned d2,
                           input int unsigned d3, input int unsigned sa, input int unsigned ba);
    apb_write(REG_SIZE_DIM0, d0);
    apb_write(REG_SIZE_DIM1, d1);
    apb_write(REG_SIZE_DIM2, d2);
    apb_write(REG_SIZE_DIM3, d3);
    apb_write(REG_SEQ_AXIS, sa);
    apb_write(REG_BATCH_AXIS, ba);
    extent_cfg[0]  = EXT_W'(d0);
    extent_cfg[1]  = EXT_W'(d1);
    extent_cfg[2]  = EXT_W'(d2);
    extent_cfg[3]  = EXT_W'(d3);
    seq_axis_cfg   = DIM_W'(sa);
    batch_axis_cfg = DIM_W'(ba);
  endtask

  // Returns once every word is accepted and answered, plus time for a trailing write.
  task automatic wait_idle();
    while (cmds_accepted != cmds_issued || expected_reads.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default: begin send_idle_pct = 6; recv_stall_pct = 6; end
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a 2x5 tensor reversed along dim1, one length clamped, edge indexes.
    configure(2, 5, 1, 1, 1, 0);
    for (int i = 0; i < 10; i++) begin
      push_cmd(CMD_WR_ELEM, IDX_W'(i),
               (i == 0) ? 32'h0 : (i == 9) ? 32'hFFFF_FFFF : 32'h1000_0000 + i, '0);
    end
    push_cmd(CMD_WR_LEN, 12'd0, '0, 13'd3);
    push_cmd(CMD_WR_LEN, 12'd1, '1, 13'd4096);
    push_cmd(CMD_WR_LEN, 12'd4095, '0, 13'd7);
    push_cmd(CMD_UNUSED, 12'd0, '1, '1);
    push_read(12'd0);
    push_read(12'd1);
    push_read(12'd2);
    push_read(12'd4);
    push_read(12'd5);
    push_read(12'd9);
    push_read(12'd10);
    push_read(12'd4095);

    for (int p = 1; p <= 8; p++) begin
      wait_idle();
      case (p)
        1: configure(3, 4, 5, 2, 2, 1);
        2: configure(0, 8, 0, 6, 3, 1);      // zero extents count as one
        3: configure(1, 512, 8, 1, 2, 1);    // batch coordinates past the length table
        4: configure(4096, 1, 1, 1, 0, 3);
        5: configure(2, 3, 4, 4096, 0, 3);   // reversed reads can land past the store
        6: configure(4, 4, 4, 4, 1, 1);      // equal axes pass data through
        7: configure(5, 1, 7, 9, 0, 3);
        default: configure(4096, 4096, 4096, 4096, 3, 0);
      endcase
      set_idling(p % 4);
      random_items(45);
      wait_idle();
      random_items(45);
    end
    wait_idle();

    if (expected_reads.size() != 0) begin
      $error("%0d expected results never arrived", expected_reads.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
